// File: src/bg_tilemap_fetch_decode_unit_defines.svh
// Assertion macros shared by the tilemap fetch and decode RTL.
`ifndef BG_TILEMAP_FETCH_DECODE_UNIT_DEFINES_SVH
`define BG_TILEMAP_FETCH_DECODE_UNIT_DEFINES_SVH

// Check a condition that must hold in the cycle after a trigger.
`define BGTF_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

// Check a condition in the same cycle as a trigger.
`define BGTF_ASSERT_SAME(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

// File: src/bgtf_pkg.sv
// Types, register codes and helper functions for the tilemap fetch and decode unit.
package bgtf_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAP_BASE       = 3'd0,
        REG_MAP_SIZE       = 3'd1,
        REG_TALL_TILES     = 3'd2,
        REG_HIRES          = 3'd3,
        REG_COLOR_DEPTH    = 3'd4,
        REG_CHAR_BASE      = 3'd5,
        REG_PRIORITY_PAIR  = 3'd6,
        REG_PALETTE_OFFSET = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] map_base;
        logic [1:0]  map_size;
        logic        tall_tiles;
        logic        hires;
        logic [1:0]  color_depth;
        logic [15:0] char_base;
        logic [7:0]  priority_pair;
        logic [6:0]  palette_offset;
    } cfg_t;

    // Depth code three behaves as eight bits per pixel.
    function automatic logic [1:0] eff_depth(input logic [1:0] code);
        eff_depth = (code == 2'd3) ? 2'd2 : code;
    endfunction

    // Low-bit mask for a map dimension of 2**bits pixels.
    function automatic logic [10:0] wrap_mask(input logic [3:0] bits);
        logic [11:0] full;
        full      = ~(12'hfff << bits);
        wrap_mask = full[10:0];
    endfunction

endpackage

// File: src/bgtf_if.sv
// Item and result channel interfaces of the tilemap fetch and decode unit.
interface bgtf_item_if;
    logic        valid;
    logic        ready;
    logic [15:0] h_offset;
    logic [15:0] v_offset;
    logic [15:0] tile_entry;

    modport source (output valid, h_offset, v_offset, tile_entry, input ready);
    modport sink   (input valid, h_offset, v_offset, tile_entry, output ready);
endinterface

interface bgtf_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] map_address;
    logic [11:0] tile_number;
    logic [2:0]  pixel_row;
    logic        flip_x;
    logic        flip_y;
    logic [3:0]  tile_priority;
    logic [2:0]  palette_number;
    logic [10:0] palette_index;

    modport source (output valid, map_address, tile_number, pixel_row, flip_x, flip_y,
                    tile_priority, palette_number, palette_index, input ready);
    modport sink   (input valid, map_address, tile_number, pixel_row, flip_x, flip_y,
                    tile_priority, palette_number, palette_index, output ready);
endinterface

// File: src/bgtf_cfg_regs.sv
// Configuration register file of the tilemap fetch and decode unit.
module bgtf_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_en,
    input  logic [bgtf_pkg::CFG_INDEX_W-1:0]    index,
    input  logic [bgtf_pkg::CFG_DATA_W-1:0]     data,
    output bgtf_pkg::cfg_t                      cfg
);
    import bgtf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (cfg_reg_t'(index))
                REG_MAP_BASE:       cfg_next.map_base       = data;
                REG_MAP_SIZE:       cfg_next.map_size       = data[1:0];
                REG_TALL_TILES:     cfg_next.tall_tiles     = data[0];
                REG_HIRES:          cfg_next.hires          = data[0];
                REG_COLOR_DEPTH:    cfg_next.color_depth    = data[1:0];
                REG_CHAR_BASE:      cfg_next.char_base      = data;
                REG_PRIORITY_PAIR:  cfg_next.priority_pair  = data[7:0];
                REG_PALETTE_OFFSET: cfg_next.palette_offset = data[6:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/bg_tilemap_fetch_decode_unit.sv
// Top level of the background tilemap fetch and decode unit.
// Usage:
//   items   : one transaction carries a scrolled h_offset, v_offset and the
//             tilemap word read for that spot.
//   results : one transaction per item: tilemap byte address, character
//             index, mirrored pixel row, flip bits, priority, palette number
//             and palette index.
//   cfg_*   : write port for the eight layer registers; write only while no
//             transaction is in flight.
// The pipeline has three register stages: offset wrap and map-word decode,
// quadrant position, character base add and palette index, address add.
// Throughput is one transaction per cycle while results.ready stays high.
// Reset clears every stage valid bit and the layer registers to zero. When
// the receiver stalls the output stage holds its result and the earlier
// stages keep filling until every stage holds a transaction, then
// items.ready drops; nothing is lost or repeated.
`include "bg_tilemap_fetch_decode_unit_defines.svh"

module bg_tilemap_fetch_decode_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    bgtf_item_if.sink                        items,
    bgtf_result_if.source                    results,
    input  logic                             cfg_write_en,
    input  logic [bgtf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bgtf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bgtf_pkg::*;

    cfg_t        cfg;
    logic [1:0]  depth;
    logic        wide_tiles;

    bgtf_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .write_en (cfg_write_en),
        .index    (cfg_index),
        .data     (cfg_data),
        .cfg      (cfg)
    );

    assign depth      = eff_depth(cfg.color_depth);
    // Hires forces 16-pixel-wide tiles.
    assign wide_tiles = cfg.hires | cfg.tall_tiles;

    // Per-stage advance: a stage takes new data when empty or draining.
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;

    assign s3_ready    = !s3_valid_reg || results.ready;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign items.ready = s1_ready;

    // ---------------------------------------------------------------
    // Stage 1: wrap the offsets and decode the map word.
    // ---------------------------------------------------------------
    logic [10:0] s1_h_reg,     s1_h_next;
    logic [10:0] s1_v_reg,     s1_v_next;
    logic [9:0]  s1_char_reg,  s1_char_next;
    logic        s1_fx_reg,    s1_fx_next;
    logic        s1_fy_reg,    s1_fy_next;
    logic [3:0]  s1_pri_reg,   s1_pri_next;
    logic [2:0]  s1_pnum_reg,  s1_pnum_next;
    logic [2:0]  s1_row_reg,   s1_row_next;

    logic [3:0]  h_bits;
    logic [3:0]  v_bits;
    logic        step_col;
    logic        step_row;

    always_comb
    begin
        // Map width in pixels is 2**h_bits, height 2**v_bits.
        h_bits = 4'd8 + 4'(cfg.hires) + 4'(cfg.tall_tiles) + 4'(cfg.map_size[0]);
        v_bits = 4'd8 + 4'(cfg.hires) + 4'(cfg.tall_tiles) + 4'(cfg.map_size[1]);

        s1_h_next = items.h_offset[10:0] & wrap_mask(h_bits);
        s1_v_next = items.v_offset[10:0] & wrap_mask(v_bits);

        s1_fy_next   = items.tile_entry[15];
        s1_fx_next   = items.tile_entry[14];
        s1_pri_next  = items.tile_entry[13] ? cfg.priority_pair[7:4]
                                            : cfg.priority_pair[3:0];
        s1_pnum_next = items.tile_entry[12:10];

        // Pick the sub-character of a 16-pixel tile; wraps in the 10-bit field.
        step_col     = wide_tiles && (items.h_offset[3] != items.tile_entry[14]);
        step_row     = cfg.tall_tiles && (items.v_offset[3] != items.tile_entry[15]);
        s1_char_next = items.tile_entry[9:0] + 10'(step_col) + {5'd0, step_row, 4'd0};

        s1_row_next  = items.v_offset[2:0] ^ {3{items.tile_entry[15]}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && items.valid)
        begin
            s1_h_reg    <= s1_h_next;
            s1_v_reg    <= s1_v_next;
            s1_char_reg <= s1_char_next;
            s1_fx_reg   <= s1_fx_next;
            s1_fy_reg   <= s1_fy_next;
            s1_pri_reg  <= s1_pri_next;
            s1_pnum_reg <= s1_pnum_next;
            s1_row_reg  <= s1_row_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: quadrant position, character base add, palette index.
    // ---------------------------------------------------------------
    logic [11:0] s2_pos_reg,   s2_pos_next;
    logic [11:0] s2_tnum_reg,  s2_tnum_next;
    logic [10:0] s2_pidx_reg,  s2_pidx_next;
    logic        s2_fx_reg;
    logic        s2_fy_reg;
    logic [3:0]  s2_pri_reg;
    logic [2:0]  s2_pnum_reg;
    logic [2:0]  s2_row_reg;

    logic [4:0]  tx_low;
    logic [4:0]  ty_low;
    logic        tx_quad;
    logic        ty_quad;
    logic [11:0] quad_x;
    logic [11:0] quad_y;
    logic [11:0] base_chars;
    logic [11:0] depth_mask;
    logic [12:0] tnum_sum;
    logic [10:0] pal_shift;

    always_comb
    begin
        tx_low  = wide_tiles ? s1_h_reg[8:4] : s1_h_reg[7:3];
        tx_quad = wide_tiles ? s1_h_reg[9]   : s1_h_reg[8];
        ty_low  = cfg.tall_tiles ? s1_v_reg[8:4] : s1_v_reg[7:3];
        ty_quad = cfg.tall_tiles ? s1_v_reg[9]   : s1_v_reg[8];

        // Right-hand screens sit one 32x32 screen on; lower ones after all upper ones.
        quad_x = cfg.map_size[0] ? 12'h400 : 12'h000;
        quad_y = cfg.map_size[1] ? (cfg.map_size[0] ? 12'h800 : 12'h400) : 12'h000;

        s2_pos_next = {2'b00, ty_low, tx_low}
                    + (ty_quad ? quad_y : 12'h000)
                    + (tx_quad ? quad_x : 12'h000);

        case (depth)
            2'd0:    base_chars = cfg.char_base[15:4];
            2'd1:    base_chars = {1'b0, cfg.char_base[15:5]};
            default: base_chars = {2'b00, cfg.char_base[15:6]};
        endcase
        depth_mask   = 12'hfff >> depth;
        tnum_sum     = {3'b000, s1_char_reg} + {1'b0, base_chars};
        s2_tnum_next = tnum_sum[11:0] & depth_mask;

        case (depth)
            2'd0:    pal_shift = {6'd0, s1_pnum_reg, 2'b00};
            2'd1:    pal_shift = {4'd0, s1_pnum_reg, 4'h0};
            default: pal_shift = {s1_pnum_reg, 8'h00};
        endcase
        s2_pidx_next = {4'd0, cfg.palette_offset} + pal_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_pos_reg  <= s2_pos_next;
            s2_tnum_reg <= s2_tnum_next;
            s2_pidx_reg <= s2_pidx_next;
            s2_fx_reg   <= s1_fx_reg;
            s2_fy_reg   <= s1_fy_reg;
            s2_pri_reg  <= s1_pri_reg;
            s2_pnum_reg <= s1_pnum_reg;
            s2_row_reg  <= s1_row_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: tilemap byte address; output register.
    // ---------------------------------------------------------------
    logic [15:0] s3_addr_reg, s3_addr_next;
    logic [11:0] s3_tnum_reg;
    logic [10:0] s3_pidx_reg;
    logic        s3_fx_reg;
    logic        s3_fy_reg;
    logic [3:0]  s3_pri_reg;
    logic [2:0]  s3_pnum_reg;
    logic [2:0]  s3_row_reg;

    // Two bytes per map word; wrap to 16 bits.
    assign s3_addr_next = cfg.map_base + {3'b000, s2_pos_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_addr_reg <= s3_addr_next;
            s3_tnum_reg <= s2_tnum_reg;
            s3_pidx_reg <= s2_pidx_reg;
            s3_fx_reg   <= s2_fx_reg;
            s3_fy_reg   <= s2_fy_reg;
            s3_pri_reg  <= s2_pri_reg;
            s3_pnum_reg <= s2_pnum_reg;
            s3_row_reg  <= s2_row_reg;
        end
    end

    assign results.valid          = s3_valid_reg;
    assign results.map_address    = s3_addr_reg;
    assign results.tile_number    = s3_tnum_reg;
    assign results.pixel_row      = s3_row_reg;
    assign results.flip_x         = s3_fx_reg;
    assign results.flip_y         = s3_fy_reg;
    assign results.tile_priority  = s3_pri_reg;
    assign results.palette_number = s3_pnum_reg;
    assign results.palette_index  = s3_pidx_reg;

    // ---------------------------------------------------------------
    // Assertions: every accepted transaction moves into the next stage; items.ready drops only on a full, stalled pipe.
    // ---------------------------------------------------------------
    logic pipe_full;

    assign pipe_full = s1_valid_reg && s2_valid_reg && s3_valid_reg;

    `BGTF_ASSERT_NEXT(a_stage1_load, items.valid && items.ready, s1_valid_reg, "lost at stage 1")
    `BGTF_ASSERT_NEXT(a_stage2_load, s1_valid_reg && s2_ready, s2_valid_reg, "lost at stage 2")
    `BGTF_ASSERT_NEXT(a_stage3_load, s2_valid_reg && s3_ready, results.valid, "lost at stage 3")
    `BGTF_ASSERT_SAME(a_full_stall, !items.ready, pipe_full && !results.ready, "early stall")

endmodule

// File: dv/tb_bg_tilemap_fetch_decode_unit.sv
// Testbench for the background tilemap fetch and decode unit, self-checking.
`timescale 1ns / 100ps

module tb_bg_tilemap_fetch_decode_unit;

    import bgtf_pkg::*;

    // Stall of the order of a whole test phase with nothing moving means a hang.
    localparam int unsigned HANG_LIMIT   = 2000;
    // Three register stages, plus a little margin for the final quiet period.
    localparam int unsigned SETTLE_TICKS = 8;
    localparam int unsigned RANDOM_PHASES    = 12;
    localparam int unsigned ITEMS_PER_PHASE  = 36;

    typedef enum int unsigned {
        STALL_NONE,     // receiver always ready
        STALL_SCATTER,  // about one cycle in three stalled
        STALL_RUNS      // occasional runs of back-to-back stalled cycles
    } stall_mode_t;

    // One decoded tile fetch, as the result channel presents it.
    typedef struct packed {
        logic [15:0] map_address;
        logic [11:0] tile_number;
        logic [2:0]  pixel_row;
        logic        flip_x;
        logic        flip_y;
        logic [3:0]  tile_priority;
        logic [2:0]  palette_number;
        logic [10:0] palette_index;
    } fetch_result_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bgtf_item_if   items_ch ();
    bgtf_result_if results_ch ();

    // Layer registers as the block should currently hold them.
    cfg_t layer_regs = '0;

    // Decoded fetches still owed by the block, oldest first.
    fetch_result_t pending_fetches[$];

    int unsigned mismatch_count = 0;

    // Sender bookkeeping: burst length left, whether gaps are allowed in this
    // phase, and whether valid is currently driven high.
    int unsigned burst_left    = 0;
    bit          sender_idles  = 1'b1;
    bit          item_driven   = 1'b0;

    bg_tilemap_fetch_decode_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (items_ch),
        .results      (results_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Work out the fetch for one scrolled position and map word under the
    // given layer settings.
    function automatic fetch_result_t predict_fetch(input cfg_t c, input logic [15:0] h_in,
                                                    input logic [15:0] v_in,
                                                    input logic [15:0] entry);
        fetch_result_t r;
        int unsigned depth, tile_h_bits, tile_w_bits, span_x, span_y;
        int unsigned h, v, quad_x, quad_y, col, line, pos, chr;
        logic hflip, vflip;

        // Depth code three falls back to eight bits per pixel.
        depth       = (c.color_depth == 2'd3) ? 2 : c.color_depth;
        tile_h_bits = c.tall_tiles ? 4 : 3;
        tile_w_bits = c.hires ? 4 : tile_h_bits;

        // Map span in pixels; in hires the vertical span scales with the 512 width too.
        span_x = c.hires ? 512 : 256;
        if (tile_h_bits == 4)
            span_x = span_x << 1;
        span_y = span_x;
        if (c.map_size[0])
            span_x = span_x << 1;
        if (c.map_size[1])
            span_y = span_y << 1;
        h = h_in & (span_x - 1);
        v = v_in & (span_y - 1);

        // Each 32x32 screen quadrant takes 1024 map words; the lower pair
        // sits after both upper ones when the map is doubled both ways.
        quad_x = c.map_size[0] ? 1024 : 0;
        quad_y = c.map_size[1] ? 1024 : 0;
        if (c.map_size == 2'd3)
            quad_y = quad_y << 1;

        col  = h >> tile_w_bits;
        line = v >> tile_h_bits;
        pos  = ((line & 'h1f) << 5) + (col & 'h1f);
        if (line & 'h20)
            pos = pos + quad_y;
        if (col & 'h20)
            pos = pos + quad_x;
        r.map_address = 16'((c.map_base + (pos << 1)) & 'hffff);

        vflip = entry[15];
        hflip = entry[14];
        r.flip_x = hflip;
        r.flip_y = vflip;
        r.tile_priority  = entry[13] ? c.priority_pair[7:4] : c.priority_pair[3:0];
        r.palette_number = entry[12:10];
        r.palette_index  = 11'((c.palette_offset + (int'(entry[12:10]) << (2 << depth)))
                               & 'h7ff);

        // Sub-tile steps act on the whole word, then wrap within the 10-bit field.
        chr = entry;
        if (tile_w_bits == 4 && (h[3] != hflip))
            chr = chr + 1;
        if (tile_h_bits == 4 && (v[3] != vflip))
            chr = chr + 16;
        chr = chr & 'h3ff;
        chr = chr + (c.char_base >> (4 + depth));
        chr = chr & ('hfff >> depth);
        r.tile_number = chr[11:0];

        r.pixel_row = v[2:0] ^ {3{vflip}};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one tile fetch and hold it until the block takes it. The sender
    // runs in bursts of random length, dropping valid for a random gap
    // between bursts when idling is allowed in this phase.
    task automatic send_fetch(input logic [15:0] h, input logic [15:0] v,
                              input logic [15:0] entry);
        int unsigned gap;

        if (burst_left == 0)
        begin
            gap        = sender_idles ? $urandom_range(0, 4) : 0;
            burst_left = $urandom_range(1, 12);
            if (gap != 0)
            begin
                if (item_driven)
                begin
                    items_ch.valid <= 1'b0;
                    item_driven = 1'b0;
                end
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;

        items_ch.valid      <= 1'b1;
        items_ch.h_offset   <= h;
        items_ch.v_offset   <= v;
        items_ch.tile_entry <= entry;
        item_driven = 1'b1;

        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);

        // Accepted at this edge: record what the block owes for it.
        pending_fetches.push_back(predict_fetch(layer_regs, h, v, entry));
    endtask

    // Drop valid and hold until every outstanding fetch has come back.
    task automatic drain_fetches();
        if (item_driven)
        begin
            items_ch.valid <= 1'b0;
            item_driven = 1'b0;
        end
        burst_left = 0;
        while (pending_fetches.size() != 0)
            @(posedge clk);
    endtask

    // Drive one register write; the enable is left high for the caller to drop.
    task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
    endtask

    // Quiesce the block, then write all eight layer registers back to back.
    task automatic apply_settings(input cfg_t c);
        drain_fetches();
        put_reg(REG_MAP_BASE,       c.map_base);
        put_reg(REG_MAP_SIZE,       CFG_DATA_W'(c.map_size));
        put_reg(REG_TALL_TILES,     CFG_DATA_W'(c.tall_tiles));
        put_reg(REG_HIRES,          CFG_DATA_W'(c.hires));
        put_reg(REG_COLOR_DEPTH,    CFG_DATA_W'(c.color_depth));
        put_reg(REG_CHAR_BASE,      c.char_base);
        put_reg(REG_PRIORITY_PAIR,  CFG_DATA_W'(c.priority_pair));
        put_reg(REG_PALETTE_OFFSET, CFG_DATA_W'(c.palette_offset));
        cfg_write_en <= 1'b0;
        layer_regs = c;
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        c.map_base       = 16'($urandom);
        c.map_size       = 2'($urandom_range(0, 3));
        c.tall_tiles     = 1'($urandom_range(0, 1));
        c.hires          = 1'($urandom_range(0, 1));
        // Mostly legal depths, now and then the code that aliases to eight bits.
        c.color_depth    = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        c.char_base      = 16'($urandom);
        c.priority_pair  = 8'($urandom);
        c.palette_offset = 7'($urandom_range(0, 96));
        return c;
    endfunction

    // Every field at its top legal value.
    function automatic cfg_t max_settings();
        cfg_t c;
        c.map_base       = 16'hffff;
        c.map_size       = 2'd3;
        c.tall_tiles     = 1'b1;
        c.hires          = 1'b1;
        c.color_depth    = 2'd2;
        c.char_base      = 16'hffff;
        c.priority_pair  = 8'hff;
        c.palette_offset = 7'd96;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers straight out of reset: all zero, no write yet.
    task automatic test_reset_values();
        send_fetch(16'h1234, 16'h5678, 16'he7ff);
        send_fetch(16'hffff, 16'hffff, 16'hffff);
    endtask

    // Input fields at their extremes and alternating bit patterns, with every
    // register at its top value.
    task automatic test_field_extremes();
        apply_settings(max_settings());
        send_fetch(16'h0000, 16'h0000, 16'h0000);
        send_fetch(16'hffff, 16'hffff, 16'hffff);
        send_fetch(16'haaaa, 16'h5555, 16'haaaa);
        send_fetch(16'h5555, 16'haaaa, 16'h5555);
    endtask

    // Flip bits, both priority nibbles and palette spread across every depth
    // code, including code three which must behave as eight bits.
    task automatic test_depth_and_attributes();
        cfg_t c;
        int unsigned d;

        for (d = 0; d < 4; d++)
        begin
            c                = '0;
            c.map_base       = 16'h8000;
            c.map_size       = 2'd1;
            c.color_depth    = 2'(d);
            c.char_base      = 16'h1230;
            c.priority_pair  = 8'ha5;
            c.palette_offset = 7'd32;
            apply_settings(c);
            send_fetch(16'h01f7, 16'h00e5, 16'h7c15);
            send_fetch(16'h0128, 16'h0033, 16'h8012);
        end
    endtask

    // 16-pixel tiles in hires: sub-tile steps that carry out of the
    // 10-bit character field, with and without mirroring, plus a character
    // base that overflows the depth mask.
    task automatic test_subtile_wrap();
        cfg_t c;

        c            = '0;
        c.tall_tiles = 1'b1;
        c.hires      = 1'b1;
        c.char_base  = 16'hffff;
        apply_settings(c);
        send_fetch(16'h0008, 16'h0008, 16'h03ff);
        send_fetch(16'h0000, 16'h0000, 16'h43ff);
        send_fetch(16'h0008, 16'h0000, 16'h83f0);
        send_fetch(16'h0008, 16'h0008, 16'hc3ff);
    endtask

    // Three screen quadrants (upper right, lower left, lower right) with a map base that makes the address wrap.
    task automatic test_quadrants();
        cfg_t c;

        c          = '0;
        c.map_base = 16'hf000;
        c.map_size = 2'd3;
        apply_settings(c);
        send_fetch(16'h0100, 16'h0000, 16'h0001);
        send_fetch(16'h0000, 16'h0100, 16'h0002);
        send_fetch(16'h01f8, 16'h01f8, 16'h0003);
    endtask

    // Hires with a doubled height: the vertical wrap follows the 512 width,
    // so rows beyond 256 still land in the lower quadrant.
    task automatic test_hires_vertical_wrap();
        cfg_t c;

        c          = '0;
        c.map_base = 16'h0400;
        c.map_size = 2'd2;
        c.hires    = 1'b1;
        apply_settings(c);
        send_fetch(16'h03f0, 16'h0300, 16'h1400);
        send_fetch(16'hfe08, 16'h0400, 16'h2800);
        send_fetch(16'h0010, 16'hfcff, 16'h0c00);
    endtask

    // Random positions and map words over a run of settings: all-zero and
    // all-max first, then random ones. Every third phase the sender never idles.
    task automatic test_random_fetches();
        cfg_t c;
        int unsigned phase, n;

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                c = '0;
            else if (phase == 1)
            begin
                c = max_settings();
                c.color_depth = 2'd3;
            end
            else
                c = random_settings();
            apply_settings(c);
            sender_idles = (phase % 3) != 2;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_fetch(16'($urandom), 16'($urandom), 16'($urandom));
        end
        sender_idles = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    initial
    begin
        rst_n               <= 1'b0;
        items_ch.valid      <= 1'b0;
        items_ch.h_offset   <= '0;
        items_ch.v_offset   <= '0;
        items_ch.tile_entry <= '0;
        cfg_write_en        <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_field_extremes();
        test_depth_and_attributes();
        test_subtile_wrap();
        test_quadrants();
        test_hires_vertical_wrap();
        test_random_fetches();

        // Let the last results out, then allow a short quiet period.
        drain_fetches();
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_bg_tilemap_fetch_decode_unit: PASS");
        else
            $display("tb_bg_tilemap_fetch_decode_unit: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------

    // Stall the result channel in spells of random mode and length: fully
    // open, scattered stalled cycles, or runs of stalled cycles.
    initial
    begin : result_stalls
        stall_mode_t mode;
        int unsigned mode_left, stall_left;

        mode       = STALL_NONE;
        mode_left  = 0;
        stall_left = 0;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 120);
            end
            mode_left = mode_left - 1;
            case (mode)
                STALL_NONE:    results_ch.ready <= 1'b1;
                STALL_SCATTER: results_ch.ready <= ($urandom_range(0, 2) != 0);
                default:
                begin
                    if (stall_left == 0 && $urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 6);
                    if (stall_left != 0)
                    begin
                        stall_left = stall_left - 1;
                        results_ch.ready <= 1'b0;
                    end
                    else
                        results_ch.ready <= 1'b1;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
        mismatch_count++;
    endtask

    // Compare each accepted result against the oldest outstanding fetch.
    always @(posedge clk)
    begin : result_check
        fetch_result_t want;

        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (pending_fetches.size() == 0)
            begin
                $display("%0t: result with no fetch outstanding: expected none, actual 0x%0h",
                         $time, results_ch.map_address);
                mismatch_count++;
            end
            else
            begin
                want = pending_fetches.pop_front();
                if (results_ch.map_address !== want.map_address)
                    report_mismatch("map_address", want.map_address, results_ch.map_address);
                if (results_ch.tile_number !== want.tile_number)
                    report_mismatch("tile_number", want.tile_number, results_ch.tile_number);
                if (results_ch.pixel_row !== want.pixel_row)
                    report_mismatch("pixel_row", want.pixel_row, results_ch.pixel_row);
                if (results_ch.flip_x !== want.flip_x)
                    report_mismatch("flip_x", want.flip_x, results_ch.flip_x);
                if (results_ch.flip_y !== want.flip_y)
                    report_mismatch("flip_y", want.flip_y, results_ch.flip_y);
                if (results_ch.tile_priority !== want.tile_priority)
                    report_mismatch("tile_priority", want.tile_priority,
                                    results_ch.tile_priority);
                if (results_ch.palette_number !== want.palette_number)
                    report_mismatch("palette_number", want.palette_number,
                                    results_ch.palette_number);
                if (results_ch.palette_index !== want.palette_index)
                    report_mismatch("palette_index", want.palette_index,
                                    results_ch.palette_index);
            end
        end
    end

    // Count cycles in which no transaction moves on either channel; a run of
    // them longer than any legal stall means the block has hung.
    initial
    begin : hang_watch
        int unsigned quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
        $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
        $display("tb_bg_tilemap_fetch_decode_unit: FAIL");
        $finish;
    end

endmodule

// File: bg_tilemap_fetch_decode_unit.f
+incdir+src
src/bgtf_pkg.sv
src/bgtf_if.sv
src/bgtf_cfg_regs.sv
src/bg_tilemap_fetch_decode_unit.sv
dv/tb_bg_tilemap_fetch_decode_unit.sv
